// ----- hw/rtl/assert_macros.svh -----
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cdq_pkg.sv -----
package cdq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W     = 32;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [COUNT_W-1:0] SIZE_RESET = 5'd16;

    // register index, taken from the word-address bit of paddr
    localparam logic CFG_IDX_QUEUE_SIZE = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic load;
    } cdq_cmd_t;

endpackage

// ----- hw/rtl/cdq_ifs.sv -----
interface cdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [cdq_pkg::REQ_W-1:0]           req_type;
    logic signed [cdq_pkg::DATA_W-1:0]   push_value;

    modport source (output valid, req_type, push_value, input ready);
    modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface cdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [cdq_pkg::DATA_W-1:0]   pop_value;
    logic [cdq_pkg::STATUS_W-1:0]        status;
    logic [cdq_pkg::COUNT_W-1:0]         fill_count;

    modport source (output valid, pop_value, status, fill_count, input ready);
    modport sink   (input valid, pop_value, status, fill_count, output ready);
endinterface

// ----- hw/rtl/cdq_ram.sv -----
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/cdq_ctrl.sv -----
module cdq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cdq_pkg::cdq_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        cmd.exec = in_valid && in_ready;
        // output register free, or its transfer happens now
        cmd.load = (state_reg == S_RESULT) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.exec)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (cmd.load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/cdq_dp.sv -----
module cdq_dp #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdq_pkg::cdq_cmd_t                 cmd,
    input  logic                              cfg_we,
    input  logic [cdq_pkg::COUNT_W-1:0]       queue_size,
    input  logic [cdq_pkg::REQ_W-1:0]         req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0] push_value,
    output logic signed [cdq_pkg::DATA_W-1:0] pop_value,
    output logic [cdq_pkg::STATUS_W-1:0]      status,
    output logic [cdq_pkg::COUNT_W-1:0]       fill_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = ((IW > cdq_pkg::COUNT_W) ? IW : cdq_pkg::COUNT_W) + 1;

    logic [IW-1:0]   front_reg;
    logic [IW-1:0]   rear_reg;
    logic            empty_reg;
    logic [IW-1:0]   front_next;
    logic [IW-1:0]   rear_next;
    logic            empty_next;

    logic                            pop_ok_reg;
    cdq_pkg::status_t                status_reg;
    logic [cdq_pkg::COUNT_W-1:0]     count_reg;
    logic signed [cdq_pkg::DATA_W-1:0] pop_value_reg;
    logic [cdq_pkg::STATUS_W-1:0]    status_out_reg;
    logic [cdq_pkg::COUNT_W-1:0]     fill_out_reg;

    logic [CW-1:0]   qs_w;
    logic [CW-1:0]   sz;
    logic [CW-1:0]   front_w;
    logic [CW-1:0]   rear_w;
    logic [CW-1:0]   held;
    logic [CW-1:0]   held_new;
    logic [CW-1:0]   front_new_w;
    logic [CW-1:0]   rear_new_w;
    logic [CW-1:0]   waddr_w;
    logic [CW-1:0]   raddr_w;
    logic            ram_we;
    logic            ram_re;
    logic            pop_ok;
    cdq_pkg::status_t  st;
    cdq_pkg::req_type_t req;
    logic [cdq_pkg::DATA_W-1:0] rdata;

    always_comb
    begin
        qs_w    = {{(CW-cdq_pkg::COUNT_W){1'b0}}, queue_size};
        front_w = {{(CW-IW){1'b0}}, front_reg};
        rear_w  = {{(CW-IW){1'b0}}, rear_reg};
        req     = cdq_pkg::req_type_t'(req_type);

        // size in use, clamped to one..DEPTH
        if (qs_w == '0)
        begin
            sz = CW'(1);
        end
        else if (qs_w > CW'(DEPTH))
        begin
            sz = CW'(DEPTH);
        end
        else
        begin
            sz = qs_w;
        end

        // elements held: zero when empty, else distance front to rear plus one
        if (empty_reg)
        begin
            held = '0;
        end
        else if (rear_w >= front_w)
        begin
            held = rear_w - front_w + CW'(1);
        end
        else
        begin
            held = rear_w + sz - front_w + CW'(1);
        end

        front_new_w = front_w;
        rear_new_w  = rear_w;
        empty_next  = empty_reg;
        held_new    = held;
        st          = cdq_pkg::ST_OK;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        pop_ok      = 1'b0;
        waddr_w     = '0;
        raddr_w     = front_w;

        case (req) inside
            cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_REAR:
            begin
                if (held >= sz)
                begin
                    st = cdq_pkg::ST_FULL;
                end
                else if (empty_reg)
                begin
                    // first element always lands in slot zero
                    front_new_w = '0;
                    rear_new_w  = '0;
                    empty_next  = 1'b0;
                    ram_we      = 1'b1;
                    waddr_w     = '0;
                    held_new    = CW'(1);
                end
                else if (req == cdq_pkg::REQ_PUSH_FRONT)
                begin
                    front_new_w = (front_w == '0) ? sz - CW'(1) : front_w - CW'(1);
                    ram_we      = 1'b1;
                    waddr_w     = front_new_w;
                    held_new    = held + CW'(1);
                end
                else
                begin
                    rear_new_w = (rear_w + CW'(1) == sz) ? '0 : rear_w + CW'(1);
                    ram_we     = 1'b1;
                    waddr_w    = rear_new_w;
                    held_new   = held + CW'(1);
                end
            end
            default:
            begin
                if (empty_reg)
                begin
                    st = cdq_pkg::ST_EMPTY;
                end
                else
                begin
                    ram_re   = 1'b1;
                    pop_ok   = 1'b1;
                    raddr_w  = (req == cdq_pkg::REQ_POP_FRONT) ? front_w : rear_w;
                    held_new = held - CW'(1);
                    if (front_w == rear_w)
                    begin
                        // last element gone
                        front_new_w = '0;
                        rear_new_w  = '0;
                        empty_next  = 1'b1;
                    end
                    else if (req == cdq_pkg::REQ_POP_FRONT)
                    begin
                        front_new_w = (front_w + CW'(1) == sz) ? '0 : front_w + CW'(1);
                    end
                    else
                    begin
                        rear_new_w = (rear_w == '0) ? sz - CW'(1) : rear_w - CW'(1);
                    end
                end
            end
        endcase

        front_next = front_new_w[IW-1:0];
        rear_next  = rear_new_w[IW-1:0];
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.exec && ram_we),
        .waddr (waddr_w[IW-1:0]),
        .wdata (push_value),
        .re    (cmd.exec && ram_re),
        .raddr (raddr_w[IW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            pop_ok_reg <= pop_ok;
            status_reg <= st;
            count_reg  <= held_new[cdq_pkg::COUNT_W-1:0];
        end
        if (cmd.load)
        begin
            pop_value_reg  <= pop_ok_reg ? rdata : '0;
            status_out_reg <= status_reg;
            fill_out_reg   <= count_reg;
        end
    end

    assign pop_value  = pop_value_reg;
    assign status     = status_out_reg;
    assign fill_count = fill_out_reg;

endmodule

// ----- hw/rtl/circular_double_ended_queue.sv -----
// channel  | role   | payload
// ---------+--------+----------------------------------------------
// req      | sink   | req_type, push_value
// rsp      | source | pop_value, status, fill_count
// apb      | slave  | queue_size at byte address 0
//
// per request: the accepting edge does at most one store access and the index
// update; in the result state the registered store read then moves into the
// output register once that register is free, and no request is taken meanwhile
// reset empties the queue and sets queue_size to 16; the store is not cleared
// a result waiting in the output register does not block the next request,
// which is accepted and then held until the output register is free
// a queue_size write empties the queue; the store keeps its contents
module circular_double_ended_queue #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cdq_req_if.sink                           req,
    cdq_rsp_if.source                         rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cdq_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [cdq_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [cdq_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [cdq_pkg::COUNT_W-1:0] queue_size_reg;
    logic                        cfg_we;
    logic                        cfg_hit;
    cdq_pkg::cdq_cmd_t           cmd;

    // register select from the word-address bit, byte lanes ignored
    assign cfg_hit = (paddr[cdq_pkg::CFG_ADDR_W-1] == cdq_pkg::CFG_IDX_QUEUE_SIZE);
    // access phase of a write; pready is tied high
    assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
    assign pready  = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata = {{(cdq_pkg::CFG_DATA_W-cdq_pkg::COUNT_W){1'b0}}, queue_size_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_size_reg <= cdq_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            queue_size_reg <= pwdata[cdq_pkg::COUNT_W-1:0];
        end
    end

    // sequencing of accept, store access and result transfer
    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // indices, fill count, slot store and output register
    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .queue_size (queue_size_reg),
        .req_type   (req.req_type),
        .push_value (req.push_value),
        .pop_value  (rsp.pop_value),
        .status     (rsp.status),
        .fill_count (rsp.fill_count)
    );

endmodule

// ----- hw/rtl/cdq_checker.sv -----
`include "assert_macros.svh"

module cdq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [cdq_pkg::DATA_W-1:0]       pop_value,
    input logic [cdq_pkg::STATUS_W-1:0]     status,
    input logic [cdq_pkg::COUNT_W-1:0]      fill_count
);

    // refused pop reports an empty queue and no data
    `ASSERT_IMPLIES(a_empty_result, clk, rst_n, out_valid && (status == cdq_pkg::ST_EMPTY), (fill_count == '0) && (pop_value == '0), "refused pop with data or count")

    // refused push leaves a non-empty queue and no data
    `ASSERT_IMPLIES(a_full_result, clk, rst_n, out_valid && (status == cdq_pkg::ST_FULL), (fill_count != '0) && (pop_value == '0), "refused push with bad count or data")

    // one request in flight at a time
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted on consecutive cycles")

    // a stalled result stays offered
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind circular_double_ended_queue cdq_checker u_cdq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .pop_value  (rsp.pop_value),
    .status     (rsp.status),
    .fill_count (rsp.fill_count)
);
